/* rtl/core/wfd8_pkg.sv */
package wfd8_pkg;

   localparam int unsigned MAX_COLS_DEFAULT    = 1024;
   localparam int unsigned MAX_ROWS_DEFAULT    = 4096;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // widest row / column index and count over the supported grid sizes
   localparam int unsigned ROW_IDX_W = 16;
   localparam int unsigned ROW_CNT_W = 17;
   localparam int unsigned COL_IDX_W = 12;
   localparam int unsigned COL_CNT_W = 13;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COURANT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COL_COURANT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ROW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_COL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_FIRST  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_END    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS   = 3'd7;

   localparam int unsigned TAP_IDX_W = 5;
   localparam logic [TAP_IDX_W-1:0] TAP_CENTRE = 5'd8;
   localparam logic [TAP_IDX_W-1:0] TAP_LAST   = 5'd17;

   typedef struct packed {
      logic [16:0] row_courant_sq;
      logic [16:0] col_courant_sq;
      logic [11:0] source_row;
      logic [9:0]  source_col;
      logic [12:0] band_first_row;
      logic [12:0] band_end_row;
      logic [12:0] grid_rows;
      logic [10:0] grid_cols;
   } cfg_type;

   typedef struct packed {
      logic [ROW_IDX_W-1:0] row;
      logic [COL_IDX_W-1:0] col;
      logic signed [31:0]   cur;
      logic signed [31:0]   prev;
      logic                 emit_a;
      logic                 emit_b;
      logic                 inner;
   } cmd_type;

   typedef enum logic [3:0] {
      B_IDLE, B_FETCH, B_LOAD, B_TAPS, B_DRAIN, B_ROUND,
      B_SCALE, B_SUM, B_EMIT_A, B_EMIT_B, B_WRITE
   } back_state_type;

   // 8th-order second difference, Q.24
   function automatic logic signed [27:0] tap_coef(input logic [3:0] idx);
      logic signed [27:0] v;
      case (idx)
         4'd0, 4'd8: v = -28'sd29959;
         4'd1, 4'd7: v = 28'sd426088;
         4'd2, 4'd6: v = -28'sd3355443;
         4'd3, 4'd5: v = 28'sd26843546;
         4'd4:       v = -28'sd47768464;
         default:    v = 28'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] v;
      if (x > 64'sd2147483647)
         v = 32'sh7fffffff;
      else if (x < -64'sd2147483648)
         v = 32'sh80000000;
      else
         v = x[31:0];
      return v;
   endfunction

endpackage

/* rtl/core/wave2d_fd8_stencil_step_unit.sv */
// One time step of a 2-D acoustic wave solver with an 8th-order stencil. Grid
// points stream in raster order on req_ (current, previous and source amount);
// each beat yields zero, one or two results on rsp_, a point being emitted
// four rows after it arrives (one of the last four rows on arrival instead),
// tagged with its row and column. A small command queue parts the accepting
// front from the compute back, so input is taken while results wait. The back
// end works one point at a time through a single shared multiply-accumulate
// (18 taps, one per cycle) and one port per line store. Only an interior point
// runs the taps; a result stall holds the back end. The line stores are not
// cleared; no reset sweep is needed.
module wave2d_fd8_stencil_step_unit
   import wfd8_pkg::*;
#(
   parameter int unsigned MAX_COLS    = MAX_COLS_DEFAULT,
   parameter int unsigned MAX_ROWS    = MAX_ROWS_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [95:0]            req_tdata,  // cur_sample, prev_sample, source_amount
   input  logic                   req_tuser,  // frame_start
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [87:0]            rsp_tdata,  // out_row, out_col, next_sample,
                                              // injected_cur, zero pad
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff;
   cmd_type push_cmd, head;
   logic    push, pop, not_empty, full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_courant_sq <= 17'd16384;
         cfg_ff.col_courant_sq <= 17'd16384;
         cfg_ff.source_row     <= 12'd2048;
         cfg_ff.source_col     <= 10'd512;
         cfg_ff.band_first_row <= 13'd0;
         cfg_ff.band_end_row   <= 13'd4096;
         cfg_ff.grid_rows      <= 13'd4096;
         cfg_ff.grid_cols      <= 11'd1024;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_COURANT: cfg_ff.row_courant_sq <= csr_data;
            CSR_COL_COURANT: cfg_ff.col_courant_sq <= csr_data;
            CSR_SOURCE_ROW:  cfg_ff.source_row     <= csr_data[11:0];
            CSR_SOURCE_COL:  cfg_ff.source_col     <= csr_data[9:0];
            CSR_BAND_FIRST:  cfg_ff.band_first_row <= csr_data[12:0];
            CSR_BAND_END:    cfg_ff.band_end_row   <= csr_data[12:0];
            CSR_GRID_ROWS:   cfg_ff.grid_rows      <= csr_data[12:0];
            CSR_GRID_COLS:   cfg_ff.grid_cols      <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   wfd8_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .push(push), .push_cmd(push_cmd), .queue_full(full)
   );

   wfd8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_cmd(push_cmd),
      .pop(pop), .head(head), .not_empty(not_empty), .full(full)
   );

   wfd8_back #(.MAX_COLS(MAX_COLS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .cmd(head), .cmd_valid(not_empty), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

endmodule

/* rtl/core/wfd8_front.sv */
module wfd8_front
   import wfd8_pkg::*;
#(
   parameter int unsigned MAX_COLS = MAX_COLS_DEFAULT,
   parameter int unsigned MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [95:0]   req_tdata,
   input  logic          req_tuser,
   output logic          push,
   output cmd_type       push_cmd,
   input  logic          queue_full
);

   logic [ROW_IDX_W-1:0] row_ff, row_in;
   logic [COL_IDX_W-1:0] col_ff, col_in;
   logic [ROW_CNT_W-1:0] rows, tail, r17, pr17;
   logic [COL_CNT_W-1:0] cols, c13;
   logic [ROW_IDX_W-1:0] r;
   logic [COL_IDX_W-1:0] c;
   logic signed [31:0]   cur, prev, amt, cur_inj;
   logic                 inject, beat;
   logic [ROW_CNT_W-1:0] src_r, band_f, band_e;

   assign req_tready = !queue_full;
   assign beat       = req_tvalid && req_tready;

   assign cur  = req_tdata[31:0];
   assign prev = req_tdata[63:32];
   assign amt  = req_tdata[95:64];

   always_comb begin
      if (cfg.grid_rows == '0)
         rows = ROW_CNT_W'(1);
      else if (ROW_CNT_W'(cfg.grid_rows) > ROW_CNT_W'(MAX_ROWS))
         rows = ROW_CNT_W'(MAX_ROWS);
      else
         rows = ROW_CNT_W'(cfg.grid_rows);
      if (cfg.grid_cols == '0)
         cols = COL_CNT_W'(1);
      else if (COL_CNT_W'(cfg.grid_cols) > COL_CNT_W'(MAX_COLS))
         cols = COL_CNT_W'(MAX_COLS);
      else
         cols = COL_CNT_W'(cfg.grid_cols);
      tail = (rows > ROW_CNT_W'(4)) ? rows - ROW_CNT_W'(4) : '0;
   end

   always_comb begin
      r = req_tuser ? '0 : row_ff;
      c = req_tuser ? '0 : col_ff;
      if (ROW_CNT_W'(r) >= rows) r = '0;
      if (COL_CNT_W'(c) >= cols) c = '0;
      r17  = ROW_CNT_W'(r);
      c13  = COL_CNT_W'(c);
      pr17 = r17 - ROW_CNT_W'(4);
   end

   assign src_r  = ROW_CNT_W'(cfg.source_row);
   assign band_f = ROW_CNT_W'(cfg.band_first_row);
   assign band_e = ROW_CNT_W'(cfg.band_end_row);

   assign inject = (r17 == src_r) && (c13 == COL_CNT_W'(cfg.source_col)) &&
                   (src_r >= band_f) && (src_r < band_e);
   assign cur_inj = inject ? sat32(64'(cur) + 64'(amt)) : cur;

   always_comb begin
      push_cmd.row    = r;
      push_cmd.col    = c;
      push_cmd.cur    = cur_inj;
      push_cmd.prev   = prev;
      push_cmd.emit_a = (r17 >= ROW_CNT_W'(4)) && (pr17 < tail);
      push_cmd.emit_b = (r17 >= tail);
      push_cmd.inner  = (pr17 >= ROW_CNT_W'(4)) && (pr17 + ROW_CNT_W'(4) < rows) &&
                        (c13 >= COL_CNT_W'(4)) && (c13 + COL_CNT_W'(4) < cols) &&
                        (pr17 >= band_f) && (pr17 < band_e);
   end
   assign push = beat;

   // advance raster position
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (beat) begin
         if (c13 + COL_CNT_W'(1) >= cols) begin
            col_in = '0;
            if (r17 + ROW_CNT_W'(1) >= rows)
               row_in = '0;
            else
               row_in = r + ROW_IDX_W'(1);
         end else begin
            col_in = c + COL_IDX_W'(1);
            row_in = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

/* rtl/core/wfd8_queue.sv */
module wfd8_queue
   import wfd8_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    not_empty,
   output logic    full
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   cmd_type           slot_ff [DEPTH];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   assign head      = slot_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == CntW'(DEPTH));

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push)
         wr_in = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + PtrW'(1);
      if (pop)
         rd_in = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + PtrW'(1);
      if (push && !pop)
         cnt_in = cnt_ff + CntW'(1);
      else if (pop && !push)
         cnt_in = cnt_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/core/wfd8_back.sv */
module wfd8_back
   import wfd8_pkg::*;
#(
   parameter int unsigned MAX_COLS = MAX_COLS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  cmd_type      cmd,
   input  logic         cmd_valid,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tlast
);

   localparam int unsigned StoreDepth = 8 * MAX_COLS;
   localparam int unsigned StoreAw    = $clog2(StoreDepth);
   localparam int unsigned PrevDepth  = 4 * MAX_COLS;
   localparam int unsigned PrevAw     = $clog2(PrevDepth);

   logic [31:0] store_mem [StoreDepth];
   logic [31:0] prev_mem  [PrevDepth];

   back_state_type state_ff, state_in;
   logic [TAP_IDX_W-1:0] k_ff, k_in;

   logic [2:0]           st_row, mid_row;
   logic [COL_IDX_W-1:0] st_col;
   logic [StoreAw-1:0]   st_addr;
   logic [PrevAw-1:0]    pv_addr;
   logic                 mem_we, tap_issue, load_clr, load_a, load_b, out_free;
   logic [31:0]          store_rd_ff, prev_rd_ff;

   logic                 p1_vld_ff, p2_vld_ff, p2_vert_ff;
   logic [TAP_IDX_W-1:0] p1_k_ff;
   logic [3:0]           coef_idx;
   logic signed [31:0]   operand;
   logic signed [59:0]   prod_ff;
   logic signed [63:0]   acc_v_ff, acc_h_ff;
   logic signed [39:0]   rv_ff, rh_ff;
   logic signed [57:0]   sv_ff, sh_ff;
   logic signed [31:0]   inj_ff, old_ff, result_ff;
   logic signed [57:0]   tv, th, total;

   logic                 rsp_tvalid_ff;
   logic [87:0]          rsp_tdata_ff;
   logic                 rsp_tlast_ff;

   assign mid_row  = cmd.row[2:0] + 3'd4;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:
            if (cmd_valid)
               state_in = cmd.emit_a ? B_FETCH : (cmd.emit_b ? B_EMIT_B : B_WRITE);
         B_FETCH:  state_in = B_LOAD;
         B_LOAD:   state_in = cmd.inner ? B_TAPS : B_EMIT_A;
         B_TAPS:   if (k_ff == TAP_LAST) state_in = B_DRAIN;
         B_DRAIN:  if (!p1_vld_ff && !p2_vld_ff) state_in = B_ROUND;
         B_ROUND:  state_in = B_SCALE;
         B_SCALE:  state_in = B_SUM;
         B_SUM:    state_in = B_EMIT_A;
         B_EMIT_A: if (out_free) state_in = cmd.emit_b ? B_EMIT_B : B_WRITE;
         B_EMIT_B: if (out_free) state_in = B_WRITE;
         B_WRITE:  state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   always_comb begin
      st_row    = mid_row;
      st_col    = cmd.col;
      mem_we    = 1'b0;
      tap_issue = 1'b0;
      load_clr  = 1'b0;
      load_a    = 1'b0;
      load_b    = 1'b0;
      pop       = 1'b0;
      k_in      = k_ff;
      unique case (state_ff)
         B_LOAD: begin
            load_clr = 1'b1;
            k_in     = '0;
         end
         B_TAPS: begin
            tap_issue = 1'b1;
            k_in      = k_ff + TAP_IDX_W'(1);
            if (k_ff < TAP_CENTRE)
               st_row = cmd.row[2:0] + k_ff[2:0];
            else if (k_ff > TAP_CENTRE)
               st_col = cmd.col + COL_IDX_W'(k_ff) - COL_IDX_W'(13);
         end
         B_EMIT_A: load_a = out_free;
         B_EMIT_B: load_b = out_free;
         B_WRITE: begin
            st_row = cmd.row[2:0];
            mem_we = 1'b1;
            pop    = 1'b1;
         end
         default: ;
      endcase
   end

   assign st_addr = StoreAw'(32'(st_row) * MAX_COLS + 32'(st_col));
   assign pv_addr = PrevAw'(32'(cmd.row[1:0]) * MAX_COLS + 32'(cmd.col));

   always_ff @(posedge clock) begin
      if (mem_we)
         store_mem[st_addr] <= cmd.cur;
      store_rd_ff <= store_mem[st_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         prev_mem[pv_addr] <= cmd.prev;
      prev_rd_ff <= prev_mem[pv_addr];
   end

   // one tap per beat: read, multiply, accumulate
   assign coef_idx = (p1_k_ff > TAP_CENTRE) ? 4'(p1_k_ff - 5'd9) : p1_k_ff[3:0];
   assign operand  = (p1_k_ff == TAP_CENTRE) ? cmd.cur : $signed(store_rd_ff);

   assign tv    = (sv_ff + 58'sd32768) >>> 16;
   assign th    = (sh_ff + 58'sd32768) >>> 16;
   assign total = 58'(inj_ff) + 58'(inj_ff) - 58'(old_ff) + tv + th;

   always_ff @(posedge clock) begin
      p1_k_ff    <= k_ff;
      prod_ff    <= tap_coef(coef_idx) * operand;
      p2_vert_ff <= (p1_k_ff <= TAP_CENTRE);
      if (load_clr) begin
         acc_v_ff <= '0;
         acc_h_ff <= '0;
         inj_ff   <= $signed(store_rd_ff);
         old_ff   <= $signed(prev_rd_ff);
         result_ff <= $signed(prev_rd_ff);
      end else if (p2_vld_ff) begin
         if (p2_vert_ff)
            acc_v_ff <= acc_v_ff + 64'(prod_ff);
         else
            acc_h_ff <= acc_h_ff + 64'(prod_ff);
      end
      if (state_ff == B_ROUND) begin
         rv_ff <= 40'((acc_v_ff + 64'sd8388608) >>> 24);
         rh_ff <= 40'((acc_h_ff + 64'sd8388608) >>> 24);
      end
      if (state_ff == B_SCALE) begin
         sv_ff <= rv_ff * $signed({1'b0, cfg.row_courant_sq});
         sh_ff <= rh_ff * $signed({1'b0, cfg.col_courant_sq});
      end
      if (state_ff == B_SUM)
         result_ff <= sat32(64'(total));
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         rsp_tdata_ff <= {2'b00, inj_ff, result_ff, cmd.col[9:0],
                          12'(cmd.row - ROW_IDX_W'(4))};
         rsp_tlast_ff <= !cmd.emit_b;
      end else if (load_b) begin
         rsp_tdata_ff <= {2'b00, cmd.cur, cmd.prev, cmd.col[9:0], cmd.row[11:0]};
         rsp_tlast_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         k_ff          <= '0;
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         p1_vld_ff <= tap_issue;
         p2_vld_ff <= p1_vld_ff;
         if (load_a || load_b)
            rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

/* rtl/core/wfd8_checker.sv */
module wfd8_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_ready
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[87:86] == 2'b00)
      else $error("result padding not zero");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port stalled");

endmodule

bind wave2d_fd8_stencil_step_unit wfd8_checker u_wfd8_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .csr_ready(csr_ready)
);

/* verif/wave2d_fd8_stencil_step_unit_tb.sv */
`timescale 1ns / 1ps

module wave2d_fd8_stencil_step_unit_tb;
   import wfd8_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEM_TARGET = 1700;

   typedef struct {
      logic [31:0] cur;
      logic [31:0] prev;
      logic [31:0] amt;
      logic        first;
   } grid_point_t;

   typedef struct {
      logic [11:0] row;
      logic [9:0]  col;
      logic [31:0] next_val;
      logic [31:0] inj_val;
      logic        last;
   } point_update_t;

   logic clock;
   logic reset;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   wave2d_fd8_stencil_step_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   int m_row_cs, m_col_cs, m_src_row, m_src_col;
   int m_band_first, m_band_end, m_grid_rows, m_grid_cols;
   logic signed [31:0] cur_lines [8][1024];
   logic signed [31:0] prev_lines [4][1024];
   int pos_row, pos_col;

   point_update_t updates_due[$];
   grid_point_t   points_to_send[$];

   int mismatches = 0;
   int cycles = 0;
   logic req_beat_taken = 1'b0;
   int hold_asks = 0;
   bit sender_gappy = 1'b1;

   const longint stencil_taps[9] = '{-29959, 426088, -3355443, 26843546, -47768464,
                                     26843546, -3355443, 426088, -29959};

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic void push_update(int r, int c, longint nv, longint iv, bit last);
      point_update_t u;
      u.row = r[11:0];
      u.col = c[9:0];
      u.next_val = nv[31:0];
      u.inj_val = iv[31:0];
      u.last = last;
      updates_due.push_back(u);
   endfunction

   function automatic void advance_point(logic signed [31:0] cur_in,
                                         logic signed [31:0] prev_in,
                                         logic signed [31:0] amt_in, logic first);
      int rows, cols, tail, r, c, pr;
      longint cur, inj, old, nv, dv, dh;
      bit inner;
      rows = m_grid_rows < 1 ? 1 : (m_grid_rows > 4096 ? 4096 : m_grid_rows);
      cols = m_grid_cols < 1 ? 1 : (m_grid_cols > 1024 ? 1024 : m_grid_cols);
      tail = rows > 4 ? rows - 4 : 0;
      r = pos_row;
      c = pos_col;
      cur = cur_in;
      if (first) begin
         r = 0;
         c = 0;
      end
      if (r >= rows) r = 0;
      if (c >= cols) c = 0;
      if (r == m_src_row && c == m_src_col &&
          m_src_row >= m_band_first && m_src_row < m_band_end)
         cur = clip32(cur + longint'(amt_in));
      if (r >= 4 && r - 4 < tail) begin
         pr = r - 4;
         inj = cur_lines[pr & 7][c];
         old = prev_lines[r & 3][c];
         nv = old;
         inner = pr >= 4 && pr + 4 < rows && c >= 4 && c + 4 < cols &&
                 pr >= m_band_first && pr < m_band_end;
         if (inner) begin
            dv = 0;
            dh = 0;
            for (int k = 0; k < 8; k++)
               dv += stencil_taps[k] * longint'(cur_lines[(r - 8 + k) & 7][c]);
            dv += stencil_taps[8] * cur;
            for (int k = 0; k < 9; k++)
               dh += stencil_taps[k] * longint'(cur_lines[pr & 7][c - 4 + k]);
            dv = (dv + (64'sd1 <<< 23)) >>> 24;
            dh = (dh + (64'sd1 <<< 23)) >>> 24;
            dv = (dv * m_row_cs + (64'sd1 <<< 15)) >>> 16;
            dh = (dh * m_col_cs + (64'sd1 <<< 15)) >>> 16;
            nv = clip32(2 * inj - old + dv + dh);
         end
         push_update(pr, c, nv, inj, r < tail);
      end
      if (r >= tail)
         push_update(r, c, longint'(prev_in), cur, 1'b1);
      cur_lines[r & 7][c] = cur[31:0];
      prev_lines[r & 3][c] = prev_in;
      c++;
      if (c >= cols) begin
         c = 0;
         r++;
         if (r >= rows) r = 0;
      end
      pos_row = r;
      pos_col = c;
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_W-1:0] idx, int v);
      case (idx)
         CSR_ROW_COURANT: m_row_cs = v & 32'h1ffff;
         CSR_COL_COURANT: m_col_cs = v & 32'h1ffff;
         CSR_SOURCE_ROW:  m_src_row = v & 32'hfff;
         CSR_SOURCE_COL:  m_src_col = v & 32'h3ff;
         CSR_BAND_FIRST:  m_band_first = v & 32'h1fff;
         CSR_BAND_END:    m_band_end = v & 32'h1fff;
         CSR_GRID_ROWS:   m_grid_rows = v & 32'h1fff;
         CSR_GRID_COLS:   m_grid_cols = v & 32'h7ff;
         default: ;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender: bursts of random length, with random gaps when sender_gappy is set
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      grid_point_t p;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (points_to_send.size() > 0) begin
            p = points_to_send.pop_front();
            req_tdata <= {p.amt, p.prev, p.cur};
            req_tuser <= p.first;
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = sender_gappy ? $urandom_range(1, 12) : 0;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stall patterns, plus requested long holds
   int hold_grant = 0;
   int hold_left = 0;
   int pat_left = 0;
   int pat_mode = 0;
   logic [31:0] pat_mask = '0;
   always @(negedge clock) begin
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_grant != hold_asks) begin
            hold_grant = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (pat_left == 0) begin
            pat_mask = $urandom;
            pat_mode = $urandom_range(0, 3);
            pat_left = 64;
         end
         pat_left--;
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (pat_mode == 0) begin
            rdy = 1'b1;
         end else if (pat_mode == 1) begin
            rdy = pat_mask[pat_left % 32];
         end else if (pat_mode == 2) begin
            rdy = pat_mask[pat_left % 32] | pat_mask[(pat_left + 7) % 32];
         end else begin
            rdy = pat_mask[pat_left % 8];
         end
         rsp_tready <= rdy;
      end
   end

   // monitor: predict on accepted input beats, check accepted result beats
   always @(posedge clock) begin
      point_update_t want;
      point_update_t got;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  updates_due.size());
         $display("** wave2d_fd8_stencil_step_unit: FAILED **");
         $finish;
      end
      req_beat_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         advance_point(req_tdata[31:0], req_tdata[63:32], req_tdata[95:64], req_tuser);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row = rsp_tdata[11:0];
         got.col = rsp_tdata[21:12];
         got.next_val = rsp_tdata[53:22];
         got.inj_val = rsp_tdata[85:54];
         got.last = rsp_tlast;
         if (updates_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat row %0d col %0d", got.row, got.col);
         end else begin
            want = updates_due.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.next_val !== want.next_val || got.inj_val !== want.inj_val ||
                got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp r%0d c%0d nx %h inj %h last %b, got r%0d c%0d nx %h inj %h last %b",
                           want.row, want.col, want.next_val, want.inj_val, want.last,
                           got.row, got.col, got.next_val, got.inj_val, got.last);
            end
         end
      end
   end

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, int v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int rcs, int ccs, int sr, int sc, int bf, int be, int gr, int gc);
      write_register(CSR_ROW_COURANT, rcs);
      write_register(CSR_COL_COURANT, ccs);
      write_register(CSR_SOURCE_ROW, sr);
      write_register(CSR_SOURCE_COL, sc);
      write_register(CSR_BAND_FIRST, bf);
      write_register(CSR_BAND_END, be);
      write_register(CSR_GRID_ROWS, gr);
      write_register(CSR_GRID_COLS, gc);
   endtask

   // wait until every queued beat is out and every result back, then drain the back end
   task automatic settle();
      @(posedge clock);
      while (points_to_send.size() > 0 || req_tvalid || updates_due.size() > 0)
         @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 3))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'h0;
               default: return 32'hffffffff;
            endcase
         1, 2: return $urandom;
         default: return $urandom_range(0, 32'h07ffffff) - 32'h04000000;
      endcase
   endfunction

   function automatic void queue_point(logic [31:0] cur, logic [31:0] prev,
                                       logic [31:0] amt, logic first);
      grid_point_t p;
      p.cur = cur;
      p.prev = prev;
      p.amt = amt;
      p.first = first;
      points_to_send.push_back(p);
   endfunction

   function automatic int pick_courant();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 131071;
         2: return 65536;
         default: return $urandom_range(0, 131071);
      endcase
   endfunction

   initial begin
      int sent, phase, gr, gc, er, ec, n, sr, sc, bf, be;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      m_row_cs = 16384;
      m_col_cs = 16384;
      m_src_row = 2048;
      m_src_col = 512;
      m_band_first = 0;
      m_band_end = 4096;
      m_grid_rows = 4096;
      m_grid_cols = 1024;
      pos_row = 0;
      pos_col = 0;

      // directed: single clamped row, every point a border pass-through, source at col 3
      configure(131071, 0, 0, 3, 0, 1, 0, 9);
      queue_point(32'h7fffffff, 32'h80000000, 32'h0, 1'b1);
      queue_point(32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0);
      queue_point(32'h0, 32'hffffffff, 32'h7fffffff, 1'b0);
      queue_point(32'h7fffffff, 32'h0, 32'h7fffffff, 1'b0);   // injection clips high
      queue_point(32'hffffffff, 32'h12345678, 32'h80000000, 1'b0);
      queue_point(32'h0, 32'h0, 32'h0, 1'b1);
      queue_point(32'h1, 32'h1, 32'h1, 1'b0);
      queue_point(32'h2, 32'h2, 32'h2, 1'b0);
      queue_point(32'h80000000, 32'h55555555, 32'h80000000, 1'b0); // clips low
      queue_point(32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 1'b0);
      queue_point(32'h55555555, 32'hffffffff, 32'hffffffff, 1'b0);
      queue_point(32'h0, 32'h0, 32'h0, 1'b1);
      queue_point(32'h0, 32'h0, 32'h0, 1'b0);
      queue_point(32'h0, 32'h0, 32'h0, 1'b0);
      queue_point(32'h40000000, 32'hc0000000, 32'h40000000, 1'b0); // clips high
      queue_point(32'hc0000000, 32'h40000000, 32'hbfffffff, 1'b0); // not the source column, so no injection
      for (int i = 0; i < 6; i++)
         queue_point(pick_sample(), pick_sample(), pick_sample(), 1'b0);
      sent = 22;
      settle();

      phase = 0;
      while (sent < ITEM_TARGET) begin
         phase++;
         gr = $urandom_range(9, 16);
         gc = $urandom_range(9, 16);
         if (phase == 1) gr = 8191;
         else if (phase == 2) gc = 2047;
         else if (phase == 5) begin
            gr = 0;
            gc = 0;
         end else if ($urandom_range(0, 9) == 0) gr = $urandom_range(1, 8);
         else if ($urandom_range(0, 9) == 0) gc = $urandom_range(1, 8);
         er = gr < 1 ? 1 : (gr > 4096 ? 4096 : gr);
         ec = gc < 1 ? 1 : (gc > 1024 ? 1024 : gc);
         sr = $urandom_range(0, er);
         sc = $urandom_range(0, ec);
         if (phase == 3) begin
            sr = 4095;
            sc = 1023;
         end
         case ($urandom_range(0, 5))
            0: begin bf = 0; be = 8191; end
            1: begin bf = $urandom_range(0, er); be = $urandom_range(bf, er + 1); end
            2: begin bf = $urandom_range(1, er); be = $urandom_range(0, bf - 1); end
            3: begin bf = 8191; be = 8191; end
            default: begin bf = 0; be = er; end
         endcase
         if (phase == 4) begin
            bf = 4096;
            be = 0;
         end
         configure(pick_courant(), pick_courant(), sr, sc, bf, be, gr, gc);
         sender_gappy = (phase % 3) != 0;
         if (phase == 3) hold_asks++;
         if (er * ec <= 300)
            n = er * ec * $urandom_range(1, 2) + $urandom_range(0, 20);
         else
            n = $urandom_range(60, 150);
         for (int i = 0; i < n; i++)
            queue_point(pick_sample(), pick_sample(), pick_sample(),
                        i == 0 || $urandom_range(0, 199) == 0);
         sent += n;
         settle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && updates_due.size() == 0) begin
         $display("** wave2d_fd8_stencil_step_unit: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results never seen", mismatches, updates_due.size());
         $display("** wave2d_fd8_stencil_step_unit: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/wfd8_pkg.sv
rtl/core/wfd8_front.sv
rtl/core/wfd8_queue.sv
rtl/core/wfd8_back.sv
rtl/core/wave2d_fd8_stencil_step_unit.sv
rtl/core/wfd8_checker.sv
verif/wave2d_fd8_stencil_step_unit_tb.sv
